>>> src/rtkt_pkg.sv
// Shared types and constants for the repeater transmit key timers.
`timescale 1ns / 1ps

package rtkt_pkg;

    localparam int TIMER_W   = 22;
    localparam int ELAPSED_W = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [TIMER_W-1:0] HANG_TIME_RST   = TIMER_W'(5000);
    localparam logic [TIMER_W-1:0] TIMEOUT_RST     = TIMER_W'(180000);
    localparam logic [TIMER_W-1:0] ID_INTERVAL_RST = TIMER_W'(300000);

    typedef enum logic [1:0] {
        REG_HANG_TIME   = 2'd0,
        REG_TIMEOUT     = 2'd1,
        REG_ID_INTERVAL = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_ON   = 2'd1,
        KEY_OFF  = 2'd2
    } key_change_t;

    function automatic logic [TIMER_W-1:0] count_down(
        input logic [TIMER_W-1:0]   t,
        input logic [ELAPSED_W-1:0] d
    );
        logic [TIMER_W-1:0] dx;
        dx = TIMER_W'(d);
        return (t > dx) ? (t - dx) : '0;
    endfunction

endpackage

>>> src/rtkt_if.sv
// Valid/ready channel interfaces for activity words and keying result words.
`timescale 1ns / 1ps

interface rtkt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           rx_keyed;
    logic                           call_active;
    logic                           id_playing;
    logic                           announce_playing;
    logic [rtkt_pkg::ELAPSED_W-1:0] elapsed_ms;

    modport source (
        output valid, rx_keyed, call_active, id_playing, announce_playing, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, rx_keyed, call_active, id_playing, announce_playing, elapsed_ms,
        output ready
    );
endinterface

interface rtkt_out_if;
    logic       valid;
    logic       ready;
    logic       tx_on;
    logic [1:0] key_change;
    logic       id_request;

    modport source (
        output valid, tx_on, key_change, id_request,
        input  ready
    );
    modport sink (
        input  valid, tx_on, key_change, id_request,
        output ready
    );
endinterface

>>> src/repeater_transmit_key_timers_core.sv
// Repeater transmitter keying with hang, time-out and identification timers.
//
// in_ch carries one activity word per decision: the four activity levels and
// the milliseconds that pass after the decision. out_ch returns one word per
// input word: tx_on, the key/unkey edge and an ID request.
// A word accepted at one edge appears on out_ch after that edge. Throughput is
// one word per cycle while out_ch does not stall; the timer state updates at
// the accepting edge, so each decision sees the previous word's countdown.
// The result register decouples the sides: in_ch.ready is high whenever the
// result register is empty or is being taken, so a stalled receiver holds the
// current result and blocks new words only while it stalls.
// The APB port writes hang_time_ms (0x0), timeout_ms (0x4) and
// id_interval_ms (0x8), low 22 bits kept; reads return the register value.
// Reset restores the register defaults, clears all timers and leaves the
// transmitter unkeyed with no result pending.
`timescale 1ns / 1ps

module repeater_transmit_key_timers_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtkt_pkg::APB_AW-1:0] paddr,
    input  logic [rtkt_pkg::APB_DW-1:0] pwdata,
    output logic [rtkt_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    rtkt_in_if.sink                     in_ch,
    rtkt_out_if.source                  out_ch
);
    import rtkt_pkg::*;

    logic [TIMER_W-1:0] hang_time_reg, timeout_cfg_reg, id_interval_reg;
    logic [TIMER_W-1:0] hang_left_reg, timeout_left_reg, id_left_reg;
    logic [TIMER_W-1:0] hang_left_next, timeout_left_next, id_left_next;
    logic               tx_was_on_reg, tx_was_on_next;
    logic               out_valid_reg;
    logic               tx_on_reg, tx_on_next;
    key_change_t        key_change_reg, key_change_next;
    logic               id_request_reg, id_request_next;

    logic               wr_en, accept;
    reg_idx_t           reg_sel;
    logic               active, tx1, retry, tx;
    logic [TIMER_W-1:0] hang1, to1, to2, id1;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_sel)
            REG_HANG_TIME:   prdata = APB_DW'(hang_time_reg);
            REG_TIMEOUT:     prdata = APB_DW'(timeout_cfg_reg);
            REG_ID_INTERVAL: prdata = APB_DW'(id_interval_reg);
            default:         prdata = '0;
        endcase
    end

    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign accept      = in_ch.valid & in_ch.ready;

    // keying decision, with one retry when a keyed receiver hits time-out in a call
    always_comb
    begin
        active = in_ch.rx_keyed | in_ch.call_active | in_ch.id_playing
               | in_ch.announce_playing;
        hang1  = active ? hang_time_reg : hang_left_reg;
        to1    = active ? timeout_left_reg : timeout_cfg_reg;
        tx1    = (active | (hang1 != '0)) & (to1 != '0);
        retry  = ~tx1 & (to1 == '0) & in_ch.call_active & in_ch.rx_keyed;
        to2    = retry ? timeout_cfg_reg : to1;
        tx     = retry ? (timeout_cfg_reg != '0) : tx1;

        id_request_next = tx & (id_left_reg == '0);
        id1             = id_request_next ? id_interval_reg : id_left_reg;

        tx_was_on_next  = tx;
        if (tx && !tx_was_on_reg)
            key_change_next = KEY_ON;
        else if (!tx && tx_was_on_reg)
            key_change_next = KEY_OFF;
        else
            key_change_next = KEY_NONE;
        tx_on_next = tx;

        hang_left_next    = count_down(hang1, in_ch.elapsed_ms);
        timeout_left_next = count_down(to2, in_ch.elapsed_ms);
        id_left_next      = count_down(id1, in_ch.elapsed_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hang_time_reg    <= HANG_TIME_RST;
            timeout_cfg_reg  <= TIMEOUT_RST;
            id_interval_reg  <= ID_INTERVAL_RST;
            hang_left_reg    <= '0;
            timeout_left_reg <= '0;
            id_left_reg      <= '0;
            tx_was_on_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_sel)
                    REG_HANG_TIME:   hang_time_reg   <= pwdata[TIMER_W-1:0];
                    REG_TIMEOUT:     timeout_cfg_reg <= pwdata[TIMER_W-1:0];
                    REG_ID_INTERVAL: id_interval_reg <= pwdata[TIMER_W-1:0];
                    default:         ;
                endcase
            end
            if (accept)
            begin
                hang_left_reg    <= hang_left_next;
                timeout_left_reg <= timeout_left_next;
                id_left_reg      <= id_left_next;
                tx_was_on_reg    <= tx_was_on_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_on_reg      <= tx_on_next;
            key_change_reg <= key_change_next;
            id_request_reg <= id_request_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.tx_on      = tx_on_reg;
    assign out_ch.key_change = key_change_reg;
    assign out_ch.id_request = id_request_reg;

endmodule

>>> src/rtkt_checker.sv
// Port-level checks on the repeater transmit key timers, bound to the top level.
`timescale 1ns / 1ps

module rtkt_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       tx_on,
    input logic [1:0] key_change,
    input logic       id_request
);
    import rtkt_pkg::*;

    // key edge must leave the transmitter on
    a_key_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_change == KEY_ON |-> tx_on)
        else $error("key edge reported with transmitter off");

    // unkey edge must leave the transmitter off
    a_key_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_change == KEY_OFF |-> !tx_on)
        else $error("unkey edge reported with transmitter on");

    // ID only requested while keyed
    a_id_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && id_request |-> tx_on)
        else $error("ID request while transmitter off");

    // an accepted word yields a valid result in the cycle after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word gave no result next cycle");

endmodule

bind repeater_transmit_key_timers_core rtkt_port_checker u_rtkt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .tx_on      (out_ch.tx_on),
    .key_change (out_ch.key_change),
    .id_request (out_ch.id_request)
);
